/* rtl/iidl_pkg.sv */
`timescale 1ns / 1ps
package iidl_pkg;

  // list geometry
  localparam int DEPTH      = 64;
  localparam int WORD_BITS  = 32;

  // fixed field widths
  localparam int OP_BITS     = 2;
  localparam int POS_BITS    = 7;
  localparam int VALUE_BITS  = 32;
  localparam int COUNT_BITS  = 7;
  localparam int STATUS_BITS = 2;

  // derived widths
  localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int CMP_BITS = (POS_BITS > CNT_BITS) ? POS_BITS : CNT_BITS;

  // read-back OR tree
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FOLD
  } state_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                ins;
    logic                del;
    logic                rd;
    logic [POS_BITS-1:0] pos;
  } cmd_t;

endpackage

/* rtl/iidl_in_if.sv */
`timescale 1ns / 1ps
interface iidl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [iidl_pkg::OP_BITS-1:0]         op;
  logic [iidl_pkg::POS_BITS-1:0]        position;
  logic signed [iidl_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

/* rtl/iidl_out_if.sv */
`timescale 1ns / 1ps
interface iidl_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [iidl_pkg::VALUE_BITS-1:0] read_value;
  logic [iidl_pkg::COUNT_BITS-1:0]        count;
  logic [iidl_pkg::STATUS_BITS-1:0]       status;

  modport source (output valid, output read_value, output count, output status, input ready);
  modport sink   (input valid, input read_value, input count, input status, output ready);
endinterface

/* rtl/iidl_cell.sv */
`timescale 1ns / 1ps
module iidl_cell (
  input  logic                          clk,
  input  iidl_pkg::cmd_t                cmd,
  input  logic [iidl_pkg::IDX_BITS-1:0] index,
  input  iidl_pkg::word_t               prev_word,
  input  iidl_pkg::word_t               next_word,
  input  iidl_pkg::word_t               value,
  output iidl_pkg::word_t               word,
  output iidl_pkg::word_t               rd_word
);

  iidl_pkg::word_t                      word_r;
  iidl_pkg::word_t                      word_nxt;
  logic [iidl_pkg::CMP_BITS-1:0]        idx_c;
  logic [iidl_pkg::CMP_BITS-1:0]        pos_c;

  assign idx_c = iidl_pkg::CMP_BITS'(index);
  assign pos_c = iidl_pkg::CMP_BITS'(cmd.pos);

  always_comb begin
    word_nxt = word_r;
    if (cmd.ins) begin
      if (idx_c == pos_c) begin
        word_nxt = value;
      end else if (idx_c > pos_c) begin
        word_nxt = prev_word;
      end
    end else if (cmd.del) begin
      if (idx_c >= pos_c) begin
        word_nxt = next_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  assign rd_word = (cmd.rd && (idx_c == pos_c)) ? word_r : '0;

endmodule

/* rtl/indexed_insert_delete_list.sv */
`timescale 1ns / 1ps
// An accepted word is checked in IDLE; EXEC updates the cells and ORs the
// read-back into group registers; FOLD does the final OR into the output
// register, waiting while it is still full. A new input word is taken only in
// IDLE, also while a finished result still waits at the output.
// Reset (rst_n, synchronous, active low) empties the list and the output;
// cell contents are not cleared and stay invisible until written.
module indexed_insert_delete_list (
  input  logic        clk,
  input  logic        rst_n,
  iidl_in_if.sink     in_ch,
  iidl_out_if.source  out_ch
);

  // ---------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------
  iidl_pkg::state_t                state_r;
  iidl_pkg::state_t                state_nxt;
  logic [iidl_pkg::CNT_BITS-1:0]   count_r;
  logic [iidl_pkg::CNT_BITS-1:0]   count_nxt;
  logic                            out_valid_r;
  logic                            out_valid_nxt;

  // per-word registers (no reset)
  iidl_pkg::cmd_t                  cmd_r;
  iidl_pkg::cmd_t                  cmd_nxt;
  iidl_pkg::word_t                 value_r;
  iidl_pkg::status_t               status_r;
  iidl_pkg::status_t               status_nxt;
  logic [iidl_pkg::CNT_BITS-1:0]   res_count_r;
  iidl_pkg::word_t                 group_r [iidl_pkg::NUM_GROUPS];
  iidl_pkg::word_t                 fold_word;

  // output register
  logic [iidl_pkg::VALUE_BITS-1:0]  out_value_r;
  logic [iidl_pkg::COUNT_BITS-1:0]  out_count_r;
  iidl_pkg::status_t                out_status_r;

  logic                            in_fire;
  logic                            out_load;
  logic [iidl_pkg::CMP_BITS-1:0]   pos_c;
  logic [iidl_pkg::CMP_BITS-1:0]   cnt_c;
  logic [iidl_pkg::CMP_BITS-1:0]   depth_c;

  // cell row
  iidl_pkg::cmd_t                  cell_cmd;
  iidl_pkg::word_t                 cell_value;
  iidl_pkg::word_t                 cell_word [iidl_pkg::DEPTH];
  iidl_pkg::word_t                 cell_rd   [iidl_pkg::DEPTH];

  assign in_ch.ready = (state_r == iidl_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign pos_c   = iidl_pkg::CMP_BITS'(in_ch.position);
  assign cnt_c   = iidl_pkg::CMP_BITS'(count_r);
  assign depth_c = iidl_pkg::CMP_BITS'(iidl_pkg::DEPTH);

  // Range / full check on the incoming word, against the current count.
  // Bad position beats full on an insert.
  always_comb begin
    cmd_nxt     = '0;
    cmd_nxt.pos = in_ch.position;
    status_nxt  = iidl_pkg::ST_OK;
    count_nxt   = count_r;
    case (in_ch.op)
      iidl_pkg::OP_READ: begin
        if (pos_c < cnt_c) begin
          cmd_nxt.rd = 1'b1;
        end else begin
          status_nxt = iidl_pkg::ST_RANGE;
        end
      end
      iidl_pkg::OP_INSERT: begin
        if (pos_c > cnt_c) begin
          status_nxt = iidl_pkg::ST_RANGE;
        end else if (cnt_c >= depth_c) begin
          status_nxt = iidl_pkg::ST_FULL;
        end else begin
          cmd_nxt.ins = 1'b1;
          count_nxt   = count_r + 1'b1;
        end
      end
      iidl_pkg::OP_DELETE: begin
        if (pos_c < cnt_c) begin
          cmd_nxt.del = 1'b1;
          count_nxt   = count_r - 1'b1;
        end else begin
          status_nxt = iidl_pkg::ST_RANGE;
        end
      end
      default: begin
        // unused op code: no change, ok status
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iidl_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      iidl_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = iidl_pkg::S_EXEC;
        end
      end
      iidl_pkg::S_EXEC: begin
        state_nxt = iidl_pkg::S_FOLD;
      end
      iidl_pkg::S_FOLD: begin
        // hold the folded result until the output register frees up
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = iidl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = iidl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r       <= cmd_nxt;
      value_r     <= iidl_pkg::WORD_BITS'(in_ch.value);
      status_r    <= status_nxt;
      res_count_r <= count_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // cell row: commands reach the cells only in EXEC
  // ---------------------------------------------------------------------
  always_comb begin
    cell_cmd = cmd_r;
    if (state_r != iidl_pkg::S_EXEC) begin
      cell_cmd.ins = 1'b0;
      cell_cmd.del = 1'b0;
      cell_cmd.rd  = 1'b0;
    end
  end

  assign cell_value = value_r;

  for (genvar i = 0; i < iidl_pkg::DEPTH; i++) begin : g_cell
    iidl_pkg::word_t prev_w;
    iidl_pkg::word_t next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_prev
      assign prev_w = cell_word[i-1];
    end
    if (i == iidl_pkg::DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_next
      assign next_w = cell_word[i+1];
    end
    iidl_cell u_cell (
      .clk       (clk),
      .cmd       (cell_cmd),
      .index     (iidl_pkg::IDX_BITS'(i)),
      .prev_word (prev_w),
      .next_word (next_w),
      .value     (cell_value),
      .word      (cell_word[i]),
      .rd_word   (cell_rd[i])
    );
  end

  // ---------------------------------------------------------------------
  // read-back: OR of gated cell words, groups of eight, then across groups
  // group registers load only in EXEC so they hold through an output stall
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == iidl_pkg::S_EXEC) begin
      for (int g = 0; g < iidl_pkg::NUM_GROUPS; g++) begin
        iidl_pkg::word_t acc;
        acc = '0;
        for (int k = 0; k < iidl_pkg::GROUP_SIZE; k++) begin
          if (g * iidl_pkg::GROUP_SIZE + k < iidl_pkg::DEPTH) begin
            acc = acc | cell_rd[g * iidl_pkg::GROUP_SIZE + k];
          end
        end
        group_r[g] <= acc;
      end
    end
  end

  always_comb begin
    fold_word = '0;
    for (int g = 0; g < iidl_pkg::NUM_GROUPS; g++) begin
      fold_word = fold_word | group_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= iidl_pkg::VALUE_BITS'(fold_word);
      out_count_r  <= iidl_pkg::COUNT_BITS'(res_count_r);
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.status     = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= iidl_pkg::CNT_BITS'(iidl_pkg::DEPTH))
    else $error("stored count above depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == iidl_pkg::ST_FULL)
      |-> (out_count_r == iidl_pkg::COUNT_BITS'(iidl_pkg::DEPTH)))
    else $error("full status with list not full");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != iidl_pkg::ST_OK) |-> (out_value_r == '0))
    else $error("nonzero read value on error");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == iidl_pkg::S_EXEC && !in_ch.ready))
    else $error("accepted word did not start execution");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cell_cmd.ins, cell_cmd.del, cell_cmd.rd}))
    else $error("more than one cell command at once");
`endif

endmodule
